/* hdl/mlvc_pkg.sv */
package mlvc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GOAL_VX  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GOAL_VY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GOAL_WZ  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK     = 3'd4;

    localparam logic [CFG_DATA_W-1:0] DEADBAND_RESET = 16'd32;
    localparam logic [CFG_DATA_W-1:0] TICK_RESET     = 16'd328;

    localparam int GAIN_W = 18;
    localparam logic signed [GAIN_W-1:0] K_FF_XY = 18'sd126910;
    localparam logic signed [GAIN_W-1:0] K_FF_W  = 18'sd41942;
    localparam logic signed [GAIN_W-1:0] K_I_XY  = 18'sd127042;
    localparam logic signed [GAIN_W-1:0] K_I_W   = 18'sd41663;

    localparam int CMD_W     = 24;
    localparam int CMD_SHIFT = 12;
    localparam int CMD_ROUND = 2048;
    localparam int FRAC_SHIFT = 8;
    localparam logic signed [CMD_W-1:0] CMD_MAX = 24'sh7FFFFF;
    localparam logic signed [CMD_W-1:0] CMD_MIN = 24'sh800000;

    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic signed [CFG_DATA_W-1:0] goal_vx;
        logic signed [CFG_DATA_W-1:0] goal_vy;
        logic signed [CFG_DATA_W-1:0] goal_wz;
        logic [CFG_DATA_W-1:0]        deadband;
        logic [CFG_DATA_W-1:0]        tick_period;
    } t_cfg;

    function automatic int f_err_w(input int speed_w);
        return (speed_w + 2 > CFG_DATA_W + 1) ? speed_w + 2 : CFG_DATA_W + 1;
    endfunction

    function automatic int f_entry_w(input int speed_w);
        return 3 * (speed_w + 1) + 3 * (speed_w + 2) + 3 * f_err_w(speed_w) + 1;
    endfunction

endpackage

/* hdl/mlvc_if.sv */
interface mlvc_in_if #(parameter int SPEED_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SPEED_WIDTH-1:0] wheel_speed_1;
    logic signed [SPEED_WIDTH-1:0] wheel_speed_2;
    logic signed [SPEED_WIDTH-1:0] wheel_speed_3;
    logic signed [SPEED_WIDTH-1:0] wheel_speed_4;
    logic                          clear_integrators;

    modport source (output valid, output wheel_speed_1, output wheel_speed_2,
                    output wheel_speed_3, output wheel_speed_4,
                    output clear_integrators, input ready);
    modport sink (input valid, input wheel_speed_1, input wheel_speed_2,
                  input wheel_speed_3, input wheel_speed_4,
                  input clear_integrators, output ready);
endinterface

interface mlvc_out_if #(parameter int SPEED_WIDTH = 16);
    logic                        valid;
    logic                        ready;
    logic signed [23:0]          command_wheel_1;
    logic signed [23:0]          command_wheel_2;
    logic signed [23:0]          command_wheel_3;
    logic signed [23:0]          command_wheel_4;
    logic signed [SPEED_WIDTH:0]   body_vx;
    logic signed [SPEED_WIDTH:0]   body_vy;
    logic signed [SPEED_WIDTH:0]   body_wz;
    logic signed [SPEED_WIDTH+1:0] error_vx;
    logic signed [SPEED_WIDTH+1:0] error_vy;
    logic signed [SPEED_WIDTH+1:0] error_wz;

    modport source (output valid, output command_wheel_1, output command_wheel_2,
                    output command_wheel_3, output command_wheel_4,
                    output body_vx, output body_vy, output body_wz,
                    output error_vx, output error_vy, output error_wz,
                    input ready);
    modport sink (input valid, input command_wheel_1, input command_wheel_2,
                  input command_wheel_3, input command_wheel_4,
                  input body_vx, input body_vy, input body_wz,
                  input error_vx, input error_vy, input error_wz,
                  output ready);
endinterface

interface mlvc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/mlvc_regs.sv */
module mlvc_regs import mlvc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlvc_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_vx     <= '0;
            r_cfg.goal_vy     <= '0;
            r_cfg.goal_wz     <= '0;
            r_cfg.deadband    <= DEADBAND_RESET;
            r_cfg.tick_period <= TICK_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_GOAL_VX:  r_cfg.goal_vx     <= i_cfg.data;
                REG_GOAL_VY:  r_cfg.goal_vy     <= i_cfg.data;
                REG_GOAL_WZ:  r_cfg.goal_wz     <= i_cfg.data;
                REG_DEADBAND: r_cfg.deadband    <= i_cfg.data;
                REG_TICK:     r_cfg.tick_period <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

/* hdl/mlvc_front.sv */
module mlvc_front import mlvc_pkg::*; #(
    parameter int SPEED_WIDTH = 16,
    localparam int ERR_W   = f_err_w(SPEED_WIDTH),
    localparam int ENTRY_W = f_entry_w(SPEED_WIDTH)
) (
    mlvc_in_if.sink            i_in,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ENTRY_W-1:0] o_data
);

    localparam int SUM_W  = SPEED_WIDTH + 2;
    localparam int TRI_W  = SPEED_WIDTH + 4;
    localparam int BODY_W = SPEED_WIDTH + 1;
    localparam int EOUT_W = SPEED_WIDTH + 2;

    function automatic logic signed [BODY_W-1:0] f_body(input logic signed [SUM_W-1:0] s);
        logic signed [TRI_W-1:0] t;
        t = TRI_W'(s) + (TRI_W'(s) <<< 1);
        return BODY_W'(t >>> 3);
    endfunction

    function automatic logic signed [ERR_W-1:0] f_err(input logic signed [15:0] goal,
                                                      input logic signed [BODY_W-1:0] body);
        return ERR_W'(goal) - ERR_W'(body);
    endfunction

    function automatic logic signed [ERR_W-1:0] f_db(input logic signed [ERR_W-1:0] e,
                                                     input logic [15:0] db);
        logic [ERR_W-1:0] mag;
        mag = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
        return (mag < ERR_W'(db)) ? '0 : e;
    endfunction

    logic signed [SUM_W-1:0]  w1, w2, w3, w4;
    logic signed [SUM_W-1:0]  sx, sy, sw;
    logic signed [BODY_W-1:0] bx, by, bw;
    logic signed [ERR_W-1:0]  ex, ey, ew;

    assign w1 = SUM_W'(i_in.wheel_speed_1);
    assign w2 = SUM_W'(i_in.wheel_speed_2);
    assign w3 = SUM_W'(i_in.wheel_speed_3);
    assign w4 = SUM_W'(i_in.wheel_speed_4);

    assign sx = w1 + w2 + w3 + w4;
    assign sy = w1 - w2 + w3 - w4;
    assign sw = w1 - w2 - w3 + w4;

    assign bx = f_body(sx);
    assign by = f_body(sy);
    assign bw = f_body(sw);

    assign ex = f_err(signed'(i_cfg.goal_vx), bx);
    assign ey = f_err(signed'(i_cfg.goal_vy), by);
    assign ew = f_err(signed'(i_cfg.goal_wz), bw);

    assign o_valid    = i_in.valid;
    assign i_in.ready = i_ready;
    assign o_data = {i_in.clear_integrators, bx, by, bw,
                     ex[EOUT_W-1:0], ey[EOUT_W-1:0], ew[EOUT_W-1:0],
                     f_db(ex, i_cfg.deadband), f_db(ey, i_cfg.deadband),
                     f_db(ew, i_cfg.deadband)};

endmodule

/* hdl/mlvc_queue.sv */
module mlvc_queue import mlvc_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [Q_PW-1:0]  r_wr;
    logic [Q_PW-1:0]  r_rd;
    logic [Q_PW:0]    r_count;
    logic             push;
    logic             pop;

    function automatic logic [Q_PW-1:0] f_next(input logic [Q_PW-1:0] p);
        return (p == Q_PW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_count != (Q_PW + 1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= f_next(r_wr);
            end
            if (pop) begin
                r_rd <= f_next(r_rd);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/mlvc_back.sv */
module mlvc_back import mlvc_pkg::*; #(
    parameter int SPEED_WIDTH      = 16,
    parameter int INTEGRATOR_WIDTH = 32,
    localparam int ENTRY_W = f_entry_w(SPEED_WIDTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [ENTRY_W-1:0] i_data,
    mlvc_out_if.source         o_res
);

    localparam int IW     = INTEGRATOR_WIDTH;
    localparam int ERR_W  = f_err_w(SPEED_WIDTH);
    localparam int BODY_W = SPEED_WIDTH + 1;
    localparam int EOUT_W = SPEED_WIDTH + 2;
    localparam int MA     = (ERR_W > IW - FRAC_SHIFT) ? ERR_W : IW - FRAC_SHIFT;
    localparam int PW     = MA + GAIN_W;
    localparam int SUMI_W = PW + 1;
    localparam int CW     = PW + 4;
    localparam int QW     = CW - CMD_SHIFT;

    localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW - 1){1'b1}}};
    localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW - 1){1'b0}}};
    localparam logic signed [CW-1:0] RND   = CW'(CMD_ROUND);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_MIX  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [3:0] OP_EX   = 4'd0;
    localparam logic [3:0] OP_EY   = 4'd1;
    localparam logic [3:0] OP_EW   = 4'd2;
    localparam logic [3:0] OP_FX   = 4'd3;
    localparam logic [3:0] OP_FY   = 4'd4;
    localparam logic [3:0] OP_FW   = 4'd5;
    localparam logic [3:0] OP_HX   = 4'd6;
    localparam logic [3:0] OP_LX   = 4'd7;
    localparam logic [3:0] OP_HY   = 4'd8;
    localparam logic [3:0] OP_LY   = 4'd9;
    localparam logic [3:0] OP_HW   = 4'd10;
    localparam logic [3:0] OP_LW   = 4'd11;
    localparam logic [3:0] OP_DONE = 4'd12;

    function automatic logic signed [IW-1:0] f_isat(input logic signed [IW-1:0] acc,
                                                    input logic signed [PW-1:0] inc);
        logic signed [SUMI_W-1:0] s;
        s = SUMI_W'(acc) + SUMI_W'(inc);
        if (s > SUMI_W'(I_MAX)) begin
            return I_MAX;
        end else if (s < SUMI_W'(I_MIN)) begin
            return I_MIN;
        end
        return s[IW-1:0];
    endfunction

    function automatic logic signed [CMD_W-1:0] f_cmd(input logic signed [CW-1:0] c);
        logic signed [QW-1:0] q;
        q = QW'(c >>> CMD_SHIFT);
        if (q > QW'(CMD_MAX)) begin
            return CMD_MAX;
        end else if (q < QW'(CMD_MIN)) begin
            return CMD_MIN;
        end
        return q[CMD_W-1:0];
    endfunction

    logic                       q_clear;
    logic signed [BODY_W-1:0]   q_bx, q_by, q_bw;
    logic signed [EOUT_W-1:0]   q_ox, q_oy, q_ow;
    logic signed [ERR_W-1:0]    q_dx, q_dy, q_dw;

    assign {q_clear, q_bx, q_by, q_bw, q_ox, q_oy, q_ow, q_dx, q_dy, q_dw} = i_data;

    logic [1:0]               r_state, n_state;
    logic [3:0]               r_step, n_step;
    logic signed [IW-1:0]     r_ix, r_iy, r_iw;
    logic signed [ERR_W-1:0]  r_dx, r_dy, r_dw;
    logic signed [BODY_W-1:0] r_bx, r_by, r_bw;
    logic signed [EOUT_W-1:0] r_ox, r_oy, r_ow;
    logic signed [PW-1:0]     r_prod;
    logic signed [CW-1:0]     r_sx, r_sy, r_fw, r_tw;
    logic signed [CW-1:0]     r_p, r_m, r_d, r_e;
    logic                     r_ovalid;
    logic signed [CMD_W-1:0]  r_c1, r_c2, r_c3, r_c4;
    logic signed [BODY_W-1:0] r_res_bx, r_res_by, r_res_bw;
    logic signed [EOUT_W-1:0] r_res_ox, r_res_oy, r_res_ow;

    logic signed [MA-1:0]     mul_a;
    logic signed [GAIN_W-1:0] mul_b;
    logic signed [GAIN_W-1:0] tick_b;
    logic [3:0]               c_op;
    logic                     consume;
    logic                     pop;
    logic                     out_free;
    logic                     out_load;
    logic signed [CW-1:0]     prod_full;
    logic signed [CW-1:0]     prod_frac;

    assign o_ready   = (r_state == ST_IDLE);
    assign pop       = i_valid && o_ready;
    assign out_free  = !r_ovalid || o_res.ready;
    assign out_load  = (r_state == ST_OUT) && out_free;
    assign c_op      = r_step - 4'd1;
    assign consume   = (r_state == ST_MUL) && (r_step != 4'd0);
    assign tick_b    = {2'b00, i_cfg.tick_period};
    assign prod_full = CW'(r_prod);
    assign prod_frac = CW'(r_prod >>> FRAC_SHIFT);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_MUL) begin
            unique case (r_step)
                OP_EX: begin mul_a = MA'(r_dx); mul_b = tick_b; end
                OP_EY: begin mul_a = MA'(r_dy); mul_b = tick_b; end
                OP_EW: begin mul_a = MA'(r_dw); mul_b = tick_b; end
                OP_FX: begin mul_a = MA'(signed'(i_cfg.goal_vx)); mul_b = K_FF_XY; end
                OP_FY: begin mul_a = MA'(signed'(i_cfg.goal_vy)); mul_b = K_FF_XY; end
                OP_FW: begin mul_a = MA'(signed'(i_cfg.goal_wz)); mul_b = K_FF_W; end
                OP_HX: begin mul_a = MA'(r_ix >>> FRAC_SHIFT); mul_b = K_I_XY; end
                OP_LX: begin mul_a = MA'({1'b0, r_ix[FRAC_SHIFT-1:0]}); mul_b = K_I_XY; end
                OP_HY: begin mul_a = MA'(r_iy >>> FRAC_SHIFT); mul_b = K_I_XY; end
                OP_LY: begin mul_a = MA'({1'b0, r_iy[FRAC_SHIFT-1:0]}); mul_b = K_I_XY; end
                OP_HW: begin mul_a = MA'(r_iw >>> FRAC_SHIFT); mul_b = K_I_W; end
                OP_LW: begin mul_a = MA'({1'b0, r_iw[FRAC_SHIFT-1:0]}); mul_b = K_I_W; end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    n_state = ST_MUL;
                    n_step  = '0;
                end
            end
            ST_MUL: begin
                if (r_step == OP_DONE) begin
                    n_state = ST_MIX;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_MIX: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_ix     <= '0;
            r_iy     <= '0;
            r_iw     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (pop && q_clear) begin
                r_ix <= '0;
                r_iy <= '0;
                r_iw <= '0;
            end else if (consume) begin
                priority case (c_op)
                    OP_EX: r_ix <= f_isat(r_ix, r_prod >>> FRAC_SHIFT);
                    OP_EY: r_iy <= f_isat(r_iy, r_prod >>> FRAC_SHIFT);
                    OP_EW: r_iw <= f_isat(r_iw, r_prod >>> FRAC_SHIFT);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (pop) begin
            r_dx <= q_dx;
            r_dy <= q_dy;
            r_dw <= q_dw;
            r_bx <= q_bx;
            r_by <= q_by;
            r_bw <= q_bw;
            r_ox <= q_ox;
            r_oy <= q_oy;
            r_ow <= q_ow;
        end
        if (consume) begin
            priority case (c_op)
                OP_FX: r_sx <= prod_full;
                OP_FY: r_sy <= prod_full;
                OP_FW: r_fw <= prod_full;
                OP_HX: r_sx <= r_sx + prod_full;
                OP_LX: r_sx <= r_sx + prod_frac;
                OP_HY: r_sy <= r_sy + prod_full;
                OP_LY: r_sy <= r_sy + prod_frac;
                OP_HW: r_tw <= prod_full;
                OP_LW: r_tw <= r_tw + prod_frac;
                default: ;
            endcase
        end
        if (r_state == ST_MIX) begin
            r_p <= r_sx + r_sy + RND;
            r_m <= r_sx - r_sy + RND;
            r_d <= r_fw - r_tw;
            r_e <= r_fw + r_tw;
        end
        if (out_load) begin
            r_c1     <= f_cmd(r_p + r_d);
            r_c2     <= f_cmd(r_m - r_d);
            r_c3     <= f_cmd(r_p - r_d);
            r_c4     <= f_cmd(r_m - r_e);
            r_res_bx <= r_bx;
            r_res_by <= r_by;
            r_res_bw <= r_bw;
            r_res_ox <= r_ox;
            r_res_oy <= r_oy;
            r_res_ow <= r_ow;
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.command_wheel_1 = r_c1;
    assign o_res.command_wheel_2 = r_c2;
    assign o_res.command_wheel_3 = r_c3;
    assign o_res.command_wheel_4 = r_c4;
    assign o_res.body_vx         = r_res_bx;
    assign o_res.body_vy         = r_res_by;
    assign o_res.body_wz         = r_res_bw;
    assign o_res.error_vx        = r_res_ox;
    assign o_res.error_vy        = r_res_oy;
    assign o_res.error_wz        = r_res_ow;

endmodule

/* hdl/mecanum_lqr_velocity_control_core.sv */
// Mecanum wheel velocity controller with feedforward and integral action.
// Channels:
//   i_in   one word per control tick: four wheel speeds and a flag that
//          zeroes the three axis integrators before this tick accumulates.
//   o_res  one word per tick: four saturated wheel commands, the measured
//          body velocities and the goal-minus-measured errors.
//   i_cfg  register writes (goals, error deadband, tick period); always
//          ready; the user writes them only between ticks; not enforced.
// The back end takes a new word only when idle, once the last has left its
//   output state; its single shared multiplier forms twelve products per
//   tick (three error increments, three feedforward terms, two integrator
//   partial products per axis), then a mix step feeds the output register.
// A two-word queue sits between the kinematics front end and the multiply
//   sequencer, so up to two ticks can be taken while one is in work.
// When o_res is stalled the finished word holds in the output register;
//   the next tick runs up to its final step and waits there.
// Reset clears the integrators, the queue and the output valid, and loads
//   the register defaults.
module mecanum_lqr_velocity_control_core import mlvc_pkg::*; #(
    parameter int SPEED_WIDTH      = 16,
    parameter int INTEGRATOR_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlvc_in_if.sink     i_in,
    mlvc_cfg_if.sink    i_cfg,
    mlvc_out_if.source  o_res
);

    localparam int ENTRY_W = f_entry_w(SPEED_WIDTH);

    t_cfg               cfg;
    logic               f_valid;
    logic               f_ready;
    logic [ENTRY_W-1:0] f_data;
    logic               q_valid;
    logic               q_ready;
    logic [ENTRY_W-1:0] q_data;

    mlvc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mlvc_front #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_front (
        .i_in    (i_in),
        .i_cfg   (cfg),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    mlvc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    mlvc_back #(
        .SPEED_WIDTH      (SPEED_WIDTH),
        .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_data  (q_data),
        .o_res   (o_res)
    );

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mlvc_pkg::*;

    localparam int SPEED_W      = 16;
    localparam int INTEG_W      = 32;
    localparam int ITEMS_TOTAL  = 1550;
    localparam int DRAIN_CYCLES = 40;

    localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint CMD_HI    = (longint'(1) <<< (CMD_W - 1)) - 1;
    localparam longint CMD_LO    = -CMD_HI - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = REG_TICK + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = '1;

    localparam logic [CFG_DATA_W-1:0] GOAL_MAX = 16'h7FFF;
    localparam logic [CFG_DATA_W-1:0] GOAL_MIN = 16'h8000;
    localparam logic [CFG_DATA_W-1:0] U16_MAX  = 16'hFFFF;

    typedef struct packed {
        logic signed [CMD_W-1:0]   cmd_1;
        logic signed [CMD_W-1:0]   cmd_2;
        logic signed [CMD_W-1:0]   cmd_3;
        logic signed [CMD_W-1:0]   cmd_4;
        logic signed [SPEED_W:0]   body_vx;
        logic signed [SPEED_W:0]   body_vy;
        logic signed [SPEED_W:0]   body_wz;
        logic signed [SPEED_W+1:0] err_vx;
        logic signed [SPEED_W+1:0] err_vy;
        logic signed [SPEED_W+1:0] err_wz;
    } t_tick_result;

    typedef enum int {SPEED_SPREAD, SPEED_WINDUP, SPEED_NEAR_GOAL} t_speed_mode;

    logic i_clk;
    logic i_rst_n;

    mlvc_in_if  #(.SPEED_WIDTH(SPEED_W)) ticks_in ();
    mlvc_cfg_if                          cfg_bus ();
    mlvc_out_if #(.SPEED_WIDTH(SPEED_W)) results_out ();

    mecanum_lqr_velocity_control_core #(
        .SPEED_WIDTH(SPEED_W),
        .INTEGRATOR_WIDTH(INTEG_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ticks_in),
        .i_cfg   (cfg_bus),
        .o_res   (results_out)
    );

    t_tick_result expected_ticks[$];
    int           mismatches;
    int           items_sent;
    int           burst_left;

    longint goal_q[3];
    longint deadband_q;
    longint tick_q;
    longint integ_q[3];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic longint integ_gain(input longint acc, input longint k);
        longint hi;
        longint lo;
        hi = acc >>> FRAC_SHIFT;
        lo = acc - (hi <<< FRAC_SHIFT);
        return hi * k + ((lo * k) >>> FRAC_SHIFT);
    endfunction

    function automatic logic signed [CMD_W-1:0] to_command(input longint q20);
        return CMD_W'(clamp((q20 + CMD_ROUND) >>> CMD_SHIFT, CMD_LO, CMD_HI));
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GOAL_VX:  goal_q[0] = longint'($signed(data));
            REG_GOAL_VY:  goal_q[1] = longint'($signed(data));
            REG_GOAL_WZ:  goal_q[2] = longint'($signed(data));
            REG_DEADBAND: deadband_q = longint'(data);
            REG_TICK:     tick_q = longint'(data);
            default: ;
        endcase
    endfunction

    function automatic t_tick_result predict_tick(input longint w1, input longint w2,
                                                  input longint w3, input longint w4,
                                                  input logic clr);
        t_tick_result r;
        longint body[3];
        longint err[3];
        longint ti[3];
        longint e;
        longint inc;
        longint ffx;
        longint ffy;
        longint ffw;
        if (clr) begin
            foreach (integ_q[i]) integ_q[i] = 0;
        end
        body[0] = (3 * (w1 + w2 + w3 + w4)) >>> 3;
        body[1] = (3 * (w1 - w2 + w3 - w4)) >>> 3;
        body[2] = (3 * (w1 - w2 - w3 + w4)) >>> 3;
        for (int i = 0; i < 3; i++) begin
            err[i] = goal_q[i] - body[i];
            e = err[i];
            if ((e < 0 ? -e : e) < deadband_q) e = 0;
            inc = (e * tick_q) >>> FRAC_SHIFT;
            integ_q[i] = clamp(integ_q[i] + inc, INTEG_MIN, INTEG_MAX);
        end
        ti[0] = integ_gain(integ_q[0], longint'(K_I_XY));
        ti[1] = integ_gain(integ_q[1], longint'(K_I_XY));
        ti[2] = integ_gain(integ_q[2], longint'(K_I_W));
        ffx = goal_q[0] * longint'(K_FF_XY);
        ffy = goal_q[1] * longint'(K_FF_XY);
        ffw = goal_q[2] * longint'(K_FF_W);
        r.cmd_1   = to_command( ffw - ti[2] + ffx + ti[0] + ffy + ti[1]);
        r.cmd_2   = to_command(-ffw + ti[2] + ffx + ti[0] - ffy - ti[1]);
        r.cmd_3   = to_command(-ffw + ti[2] + ffx + ti[0] + ffy + ti[1]);
        r.cmd_4   = to_command(-ffw - ti[2] + ffx + ti[0] - ffy - ti[1]);
        r.body_vx = body[0][SPEED_W:0];
        r.body_vy = body[1][SPEED_W:0];
        r.body_wz = body[2][SPEED_W:0];
        r.err_vx  = err[0][SPEED_W+1:0];
        r.err_vy  = err[1][SPEED_W+1:0];
        r.err_wz  = err[2][SPEED_W+1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                        input logic signed [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s expected %0d got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // hold ready on a pattern: steady, mostly ready, mostly stalled, solid stall, toggling
    initial begin : result_ready_pattern
        int mode;
        int left;
        left = 0;
        mode = 0;
        results_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 4);
                left = (mode == 3) ? $urandom_range(5, 40) : $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0: results_out.ready <= 1'b1;
                1: results_out.ready <= ($urandom_range(0, 3) != 0);
                2: results_out.ready <= ($urandom_range(0, 3) == 0);
                3: results_out.ready <= 1'b0;
                default: results_out.ready <= left[0];
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_tick_result want;
        if (i_rst_n && results_out.valid && results_out.ready) begin
            if (expected_ticks.size() == 0) begin
                $error("result word with no tick waiting");
                mismatches++;
            end else begin
                want = expected_ticks.pop_front();
                check_field("command_wheel_1", want.cmd_1, results_out.command_wheel_1);
                check_field("command_wheel_2", want.cmd_2, results_out.command_wheel_2);
                check_field("command_wheel_3", want.cmd_3, results_out.command_wheel_3);
                check_field("command_wheel_4", want.cmd_4, results_out.command_wheel_4);
                check_field("body_vx", want.body_vx, results_out.body_vx);
                check_field("body_vy", want.body_vy, results_out.body_vy);
                check_field("body_wz", want.body_wz, results_out.body_wz);
                check_field("error_vx", want.err_vx, results_out.error_vx);
                check_field("error_vy", want.err_vy, results_out.error_vy);
                check_field("error_wz", want.err_wz, results_out.error_wz);
            end
        end
    end

    task automatic send_tick(input logic signed [SPEED_W-1:0] w1,
                             input logic signed [SPEED_W-1:0] w2,
                             input logic signed [SPEED_W-1:0] w3,
                             input logic signed [SPEED_W-1:0] w4,
                             input logic clr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
            if (gap != 0) begin
                ticks_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        ticks_in.valid             <= 1'b1;
        ticks_in.wheel_speed_1     <= w1;
        ticks_in.wheel_speed_2     <= w2;
        ticks_in.wheel_speed_3     <= w3;
        ticks_in.wheel_speed_4     <= w4;
        ticks_in.clear_integrators <= clr;
        do @(posedge i_clk); while (!ticks_in.ready);
        expected_ticks.push_back(predict_tick(w1, w2, w3, w4, clr));
        items_sent++;
    endtask

    // drop valid and hold until every result word is back
    task automatic quiesce();
        ticks_in.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_ticks.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        apply_reg(idx, data);
    endtask

    task automatic end_cfg();
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_goal();
        case ($urandom_range(0, 5))
            0: return GOAL_MAX;
            1: return GOAL_MIN;
            2: return '0;
            3: return CFG_DATA_W'(int'($urandom_range(0, 2048)) - 1024);
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_deadband();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return U16_MAX;
            2: return CFG_DATA_W'($urandom_range(0, 256));
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_tick();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return U16_MAX;
            2: return TICK_RESET;
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    // errors of exactly 32 pass, 31 are zeroed under the reset deadband
    task automatic test_deadband_edge();
        send_tick(-85, 0, 0, 0, 1'b0);
        send_tick(-82, 0, 0, 0, 1'b0);
        send_tick(85, 0, 0, 0, 1'b0);
        send_tick(86, 0, 0, 0, 1'b0);
    endtask

    task automatic test_kinematics_extremes();
        send_tick(0, 0, 0, 0, 1'b0);
        send_tick(32767, 32767, 32767, 32767, 1'b0);
        send_tick(-32768, -32768, -32768, -32768, 1'b0);
        send_tick(32767, -32768, 32767, -32768, 1'b0);
        send_tick(-32768, 32767, -32768, 32767, 1'b0);
        send_tick(32767, -32768, -32768, 32767, 1'b0);
    endtask

    task automatic test_clear_integrators();
        send_tick(1000, -700, 300, 2000, 1'b1);
        send_tick(1000, -700, 300, 2000, 1'b0);
    endtask

    task automatic test_register_extremes();
        quiesce();
        write_reg(REG_DEADBAND, '0);
        write_reg(REG_TICK, '0);
        write_reg(REG_GOAL_VX, GOAL_MAX);
        write_reg(REG_GOAL_VY, GOAL_MIN);
        write_reg(REG_GOAL_WZ, GOAL_MAX);
        write_reg(REG_SPARE_FIRST, U16_MAX);
        write_reg(REG_SPARE_LAST, U16_MAX);
        end_cfg();
        send_tick(1, -1, 0, 0, 1'b0);
        send_tick(-32768, 32767, 12345, -4321, 1'b0);
        quiesce();
        write_reg(REG_DEADBAND, U16_MAX);
        write_reg(REG_TICK, U16_MAX);
        write_reg(REG_GOAL_VX, GOAL_MIN);
        write_reg(REG_GOAL_VY, GOAL_MAX);
        write_reg(REG_GOAL_WZ, GOAL_MIN);
        end_cfg();
        send_tick(32767, 32767, 32767, 32767, 1'b0);
        send_tick(0, 0, 0, 0, 1'b0);
    endtask

    // wind integrators hard both ways so the commands clip
    task automatic test_command_saturation();
        quiesce();
        write_reg(REG_DEADBAND, '0);
        write_reg(REG_TICK, U16_MAX);
        write_reg(REG_GOAL_VX, GOAL_MAX);
        write_reg(REG_GOAL_VY, GOAL_MAX);
        write_reg(REG_GOAL_WZ, GOAL_MAX);
        end_cfg();
        repeat (5) send_tick(-32768, -32768, -32768, -32768, 1'b0);
        quiesce();
        write_reg(REG_GOAL_VX, GOAL_MIN);
        write_reg(REG_GOAL_VY, GOAL_MIN);
        write_reg(REG_GOAL_WZ, GOAL_MIN);
        end_cfg();
        repeat (8) send_tick(32767, 32767, 32767, 32767, 1'b0);
    endtask

    task automatic random_phase();
        t_speed_mode mode;
        int len;
        int base[4];
        logic signed [SPEED_W-1:0] w[4];
        quiesce();
        if ($urandom_range(0, 1)) write_reg(REG_GOAL_VX, pick_goal());
        if ($urandom_range(0, 1)) write_reg(REG_GOAL_VY, pick_goal());
        if ($urandom_range(0, 1)) write_reg(REG_GOAL_WZ, pick_goal());
        if ($urandom_range(0, 1)) write_reg(REG_DEADBAND, pick_deadband());
        if ($urandom_range(0, 1)) write_reg(REG_TICK, pick_tick());
        if ($urandom_range(0, 7) == 0) begin
            write_reg(CFG_INDEX_W'(REG_SPARE_FIRST +
                                   $urandom_range(0, REG_SPARE_LAST - REG_SPARE_FIRST)),
                      CFG_DATA_W'($urandom()));
        end
        end_cfg();
        mode = t_speed_mode'($urandom_range(0, 2));
        len  = (mode == SPEED_WINDUP) ? $urandom_range(60, 150) : $urandom_range(10, 60);
        foreach (base[i]) base[i] = $urandom_range(0, 1) ? 32767 : -32768;
        repeat (len) begin
            foreach (w[i]) begin
                case (mode)
                    SPEED_SPREAD: w[i] = SPEED_W'($urandom());
                    SPEED_WINDUP: w[i] = (base[i] > 0) ?
                                         SPEED_W'(base[i] - int'($urandom_range(0, 255))) :
                                         SPEED_W'(base[i] + int'($urandom_range(0, 255)));
                    default: w[i] = SPEED_W'(int'($urandom_range(0, 400)) - 200);
                endcase
            end
            send_tick(w[0], w[1], w[2], w[3], $urandom_range(0, 31) == 0);
        end
    endtask

    task automatic test_random_ticks();
        while (items_sent < ITEMS_TOTAL) random_phase();
    endtask

    initial begin
        ticks_in.valid             <= 1'b0;
        ticks_in.wheel_speed_1     <= '0;
        ticks_in.wheel_speed_2     <= '0;
        ticks_in.wheel_speed_3     <= '0;
        ticks_in.wheel_speed_4     <= '0;
        ticks_in.clear_integrators <= 1'b0;
        cfg_bus.valid              <= 1'b0;
        cfg_bus.index              <= '0;
        cfg_bus.data               <= '0;
        i_rst_n                    <= 1'b0;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;
        foreach (goal_q[i]) goal_q[i] = 0;
        foreach (integ_q[i]) integ_q[i] = 0;
        deadband_q = longint'(DEADBAND_RESET);
        tick_q     = longint'(TICK_RESET);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_deadband_edge();
        test_kinematics_extremes();
        test_clear_integrators();
        test_register_extremes();
        test_command_saturation();
        test_random_ticks();

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_ticks.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* mecanum_lqr_velocity_control_core.f */
hdl/mlvc_pkg.sv
hdl/mlvc_if.sv
hdl/mlvc_regs.sv
hdl/mlvc_front.sv
hdl/mlvc_queue.sv
hdl/mlvc_back.sv
hdl/mecanum_lqr_velocity_control_core.sv
sim/tb_top.sv
